// ----- hdl/rbtp_pkg.sv -----
// Shared types, constants and the quarter-wave sine table builder for the
// radar bin threshold-to-points block. No dependencies.
package rbtp_pkg;

  localparam int MAX_AZIMUTHS = 1024;
  localparam int MAX_BINS = 4096;
  localparam int STEPS_PER_QUARTER = 100;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int RECIP_SHIFT = 19;

  typedef enum logic [2:0] {
    REG_AZ_COUNT     = 3'd0,
    REG_AZ_OFFSET    = 3'd1,
    REG_AZ_WIN_START = 3'd2,
    REG_AZ_WIN_END   = 3'd3,
    REG_BIN_WIN_START = 3'd4,
    REG_BIN_WIN_END  = 3'd5,
    REG_PWR_THRESH   = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic [10:0] az_count;
    logic [10:0] az_offset;
    logic [10:0] az_win_start;
    logic [10:0] az_win_end;
    logic [12:0] bin_win_start;
    logic [12:0] bin_win_end;
    logic [7:0]  pwr_thresh;
  } cfg_t;

  typedef struct packed {
    logic        point;
    logic        frame_end;
    logic [11:0] adj;
    logic [11:0] bin;
    logic [7:0]  power;
  } front_t;

  // Sine of k*pi/200 from a Taylor series in Q30, rounded to frac bits.
  function automatic logic [63:0] sine_entry(input int k, input int frac);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] one;
    logic [63:0] v;
    logic signed [63:0] sum;
    logic add;
    x = (64'(k) * PI_Q30 + 64'd100) / 64'd200;
    x2 = (x * x) >> 30;
    term = x;
    sum = 64'sd0;
    add = 1'b1;
    for (int n = 1; n <= 21; n += 2) begin
      if (add) begin
        sum = sum + signed'(term);
      end else begin
        sum = sum - signed'(term);
      end
      add = !add;
      term = ((term * x2) >> 30) / 64'((n + 1) * (n + 2));
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    v = (64'(sum) + (64'd1 << (29 - frac))) >> (30 - frac);
    one = 64'd1 << frac;
    if (v > one) begin
      v = one;
    end
    return v;
  endfunction

endpackage

// ----- hdl/rbtp_cfg_regs.sv -----
// Configuration register file for the threshold-to-points block.
// Depends on rbtp_pkg for the register index codes and the cfg_t struct.
module rbtp_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [12:0]       cfg_data,
  output rbtp_pkg::cfg_t    cfg
);
  import rbtp_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_AZ_COUNT:      cfg_nxt.az_count = cfg_data[10:0];
        REG_AZ_OFFSET:     cfg_nxt.az_offset = cfg_data[10:0];
        REG_AZ_WIN_START:  cfg_nxt.az_win_start = cfg_data[10:0];
        REG_AZ_WIN_END:    cfg_nxt.az_win_end = cfg_data[10:0];
        REG_BIN_WIN_START: cfg_nxt.bin_win_start = cfg_data;
        REG_BIN_WIN_END:   cfg_nxt.bin_win_end = cfg_data;
        REG_PWR_THRESH:    cfg_nxt.pwr_thresh = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.az_count <= 11'd400;
      cfg_r.az_offset <= 11'd0;
      cfg_r.az_win_start <= 11'd0;
      cfg_r.az_win_end <= 11'd0;
      cfg_r.bin_win_start <= 13'd0;
      cfg_r.bin_win_end <= 13'd0;
      cfg_r.pwr_thresh <= 8'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- hdl/rbtp_front.sv -----
// First pipeline stage: window and threshold qualification, azimuth offset
// wrap and rotation detection. Depends on rbtp_pkg.
module rbtp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  rbtp_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [9:0]        in_azimuth_step,
  input  logic [15:0]       in_encoder_azimuth,
  input  logic [11:0]       in_bin_number,
  input  logic [7:0]        in_bin_power,
  input  logic              in_row_last,
  output logic              s1_valid,
  output rbtp_pkg::front_t  s1_data,
  input  logic              s1_ready
);
  import rbtp_pkg::*;

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  front_t      s1_data_r;
  front_t      s1_data_nxt;
  logic [15:0] prev_enc_r;
  logic [15:0] prev_enc_nxt;
  logic        stage_ready;
  logic        accept;
  logic [11:0] adj_sum;

  assign stage_ready = !s1_valid_r || s1_ready;
  assign in_stall = !stage_ready;
  assign accept = in_valid && stage_ready;
  assign s1_valid = s1_valid_r;
  assign s1_data = s1_data_r;

  always_comb begin
    s1_data_nxt.point = (int'(in_azimuth_step) < MAX_AZIMUTHS) &&
                        (int'(in_bin_number) < MAX_BINS) &&
                        ({1'b0, in_azimuth_step} >= cfg.az_win_start) &&
                        ({1'b0, in_azimuth_step} < cfg.az_win_end) &&
                        ({1'b0, in_bin_number} >= cfg.bin_win_start) &&
                        ({1'b0, in_bin_number} < cfg.bin_win_end) &&
                        (in_bin_power > cfg.pwr_thresh);
    s1_data_nxt.frame_end = in_row_last && (in_encoder_azimuth < prev_enc_r);
    adj_sum = 12'(in_azimuth_step) + 12'(cfg.az_offset);
    if (adj_sum >= 12'(cfg.az_count)) begin
      s1_data_nxt.adj = adj_sum - 12'(cfg.az_count);
    end else begin
      s1_data_nxt.adj = adj_sum;
    end
    s1_data_nxt.bin = in_bin_number;
    s1_data_nxt.power = in_bin_power;

    s1_valid_nxt = s1_valid_r;
    if (stage_ready) begin
      s1_valid_nxt = accept && (s1_data_nxt.point || s1_data_nxt.frame_end);
    end
    prev_enc_nxt = prev_enc_r;
    if (accept && in_row_last) begin
      prev_enc_nxt = in_encoder_azimuth;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      prev_enc_r <= 16'd0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      prev_enc_r <= prev_enc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r <= s1_data_nxt;
    end
  end

endmodule

// ----- hdl/rbtp_polar.sv -----
// Stages two to five: quadrant split, quarter-wave sine lookup, range
// multiplication, rounding and the output register. Depends on rbtp_pkg.
module rbtp_polar #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_valid,
  input  rbtp_pkg::front_t    s1_data,
  output logic                s1_ready,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_point_valid,
  output logic signed [16:0]  out_x_pos,
  output logic signed [16:0]  out_y_pos,
  output logic [7:0]          out_intensity,
  output logic                out_frame_end
);
  import rbtp_pkg::*;

  localparam int MW = TRIG_FRAC_BITS + 1;
  localparam int PW = 12 + MW;
  localparam logic [PW-1:0] RND = PW'(1) << (TRIG_FRAC_BITS - 5);

  logic [MW-1:0] rom [STEPS_PER_QUARTER + 1];

  for (genvar k = 0; k <= STEPS_PER_QUARTER; k++) begin : g_rom
    assign rom[k] = MW'(sine_entry(k, TRIG_FRAC_BITS));
  end

  // Stage 2 registers.
  logic        v2_r;
  logic [4:0]  q100_r;
  logic [11:0] adj2_r;
  logic        pt2_r;
  logic        fe2_r;
  logic [11:0] bin2_r;
  logic [7:0]  pwr2_r;
  // Stage 3 registers.
  logic          v3_r;
  logic [MW-1:0] cmag_r;
  logic [MW-1:0] smag_r;
  logic          cneg3_r;
  logic          sneg3_r;
  logic          pt3_r;
  logic          fe3_r;
  logic [11:0]   bin3_r;
  logic [7:0]    pwr3_r;
  // Stage 4 registers.
  logic          v4_r;
  logic [PW-1:0] px_r;
  logic [PW-1:0] py_r;
  logic          cneg4_r;
  logic          sneg4_r;
  logic          pt4_r;
  logic          fe4_r;
  logic [7:0]    pwr4_r;
  // Output registers.
  logic               v5_r;
  logic               pt5_r;
  logic signed [16:0] x5_r;
  logic signed [16:0] y5_r;
  logic [7:0]         pwr5_r;
  logic               fe5_r;

  logic          rdy2;
  logic          rdy3;
  logic          rdy4;
  logic          rdy5;
  logic [24:0]   q_prod;
  logic [6:0]    rem;
  logic [6:0]    rem_c;
  quad_t         quad;
  logic [MW-1:0] cmag_nxt;
  logic [MW-1:0] smag_nxt;
  logic          cneg_nxt;
  logic          sneg_nxt;
  logic [16:0]   rx;
  logic [16:0]   ry;
  logic [16:0]   x_nxt;
  logic [16:0]   y_nxt;

  assign rdy5 = !v5_r || !out_stall;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign s1_ready = rdy2;

  assign q_prod = 25'(s1_data.adj) * 25'(RECIP_100);

  always_comb begin
    rem = 7'(adj2_r - 12'(q100_r) * 12'd100);
    rem_c = 7'(STEPS_PER_QUARTER) - rem;
    quad = quad_t'(q100_r[1:0]);
    unique case (quad)
      QUAD_0: begin
        cmag_nxt = rom[rem_c]; cneg_nxt = 1'b0;
        smag_nxt = rom[rem];   sneg_nxt = 1'b0;
      end
      QUAD_1: begin
        cmag_nxt = rom[rem];   cneg_nxt = 1'b1;
        smag_nxt = rom[rem_c]; sneg_nxt = 1'b0;
      end
      QUAD_2: begin
        cmag_nxt = rom[rem_c]; cneg_nxt = 1'b1;
        smag_nxt = rom[rem];   sneg_nxt = 1'b1;
      end
      default: begin
        cmag_nxt = rom[rem];   cneg_nxt = 1'b0;
        smag_nxt = rom[rem_c]; sneg_nxt = 1'b1;
      end
    endcase
  end

  always_comb begin
    rx = 17'((px_r + RND) >> (TRIG_FRAC_BITS - 4));
    ry = 17'((py_r + RND) >> (TRIG_FRAC_BITS - 4));
    x_nxt = cneg4_r ? (17'd0 - rx) : rx;
    y_nxt = sneg4_r ? (17'd0 - ry) : ry;
    if (!pt4_r) begin
      x_nxt = 17'd0;
      y_nxt = 17'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_r <= s1_valid;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
      if (rdy5) begin
        v5_r <= v4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_valid) begin
      q100_r <= q_prod[RECIP_SHIFT+4:RECIP_SHIFT];
      adj2_r <= s1_data.adj;
      pt2_r <= s1_data.point;
      fe2_r <= s1_data.frame_end;
      bin2_r <= s1_data.bin;
      pwr2_r <= s1_data.power;
    end
    if (rdy3 && v2_r) begin
      cmag_r <= cmag_nxt;
      smag_r <= smag_nxt;
      cneg3_r <= cneg_nxt;
      sneg3_r <= sneg_nxt;
      pt3_r <= pt2_r;
      fe3_r <= fe2_r;
      bin3_r <= bin2_r;
      pwr3_r <= pwr2_r;
    end
    if (rdy4 && v3_r) begin
      px_r <= PW'(bin3_r) * PW'(cmag_r);
      py_r <= PW'(bin3_r) * PW'(smag_r);
      cneg4_r <= cneg3_r;
      sneg4_r <= sneg3_r;
      pt4_r <= pt3_r;
      fe4_r <= fe3_r;
      pwr4_r <= pwr3_r;
    end
    if (rdy5 && v4_r) begin
      pt5_r <= pt4_r;
      x5_r <= signed'(x_nxt);
      y5_r <= signed'(y_nxt);
      pwr5_r <= pt4_r ? pwr4_r : 8'd0;
      fe5_r <= fe4_r;
    end
  end

  assign out_valid = v5_r;
  assign out_point_valid = pt5_r;
  assign out_x_pos = x5_r;
  assign out_y_pos = y5_r;
  assign out_intensity = pwr5_r;
  assign out_frame_end = fe5_r;

`ifndef ASSERT_OFF
  a_result_has_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_point_valid || out_frame_end))
    else $error("Result carries neither a point nor a frame end.");

  a_empty_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_point_valid) |->
      (out_x_pos == 17'sd0 && out_y_pos == 17'sd0 && out_intensity == 8'd0))
    else $error("Frame-end-only result has nonzero point fields.");

  a_stage4_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !rdy5) |=> (v4_r && $stable(px_r) && $stable(py_r)))
    else $error("Product stage changed while blocked.");

  a_quarter_index: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (rem <= 7'(STEPS_PER_QUARTER)))
    else $error("Quarter-wave index out of range.");
`endif

endmodule

// ----- hdl/radar_bin_threshold_to_points_top.sv -----
// Radar bin threshold-to-points extractor: takes one range bin per clock
// while in_stall is low and emits a Cartesian point (Q4 x and y) when the bin
// passes the azimuth window, the bin window and the power threshold, plus a
// frame end flag on the last bin of a row whose encoder azimuth fell below the
// previous row's. The pipeline is five register stages deep, and one bin per
// cycle is sustained when the output is not stalled. Bins that produce no
// result are dropped in the first stage. The sine lookup reads a constant
// quarter-wave table, and each of x and y uses one 12 by (TRIG_FRAC_BITS+1)
// multiplier. Depends on rbtp_pkg, rbtp_cfg_regs, rbtp_front and
// rbtp_polar.
module radar_bin_threshold_to_points_top #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [9:0]         in_azimuth_step,
  input  logic [15:0]        in_encoder_azimuth,
  input  logic [11:0]        in_bin_number,
  input  logic [7:0]         in_bin_power,
  input  logic               in_row_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_point_valid,
  output logic signed [16:0] out_x_pos,
  output logic signed [16:0] out_y_pos,
  output logic [7:0]         out_intensity,
  output logic               out_frame_end
);
  import rbtp_pkg::*;

  cfg_t   cfg;
  logic   s1_valid;
  front_t s1_data;
  logic   s1_ready;

  rbtp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rbtp_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_azimuth_step    (in_azimuth_step),
    .in_encoder_azimuth (in_encoder_azimuth),
    .in_bin_number      (in_bin_number),
    .in_bin_power       (in_bin_power),
    .in_row_last        (in_row_last),
    .s1_valid           (s1_valid),
    .s1_data            (s1_data),
    .s1_ready           (s1_ready)
  );

  rbtp_polar #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_polar (
    .clk             (clk),
    .rst_n           (rst_n),
    .s1_valid        (s1_valid),
    .s1_data         (s1_data),
    .s1_ready        (s1_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_point_valid (out_point_valid),
    .out_x_pos       (out_x_pos),
    .out_y_pos       (out_y_pos),
    .out_intensity   (out_intensity),
    .out_frame_end   (out_frame_end)
  );

endmodule

// ----- verif/radar_bin_threshold_to_points_top_test.sv -----
// Self-checking testbench for radar_bin_threshold_to_points_top: a queue-fed
// driver, a point predictor and a monitor that checks every result in order.
// Depends on rbtp_pkg and the radar_bin_threshold_to_points_top RTL.
module radar_bin_threshold_to_points_top_test;
  import rbtp_pkg::*;

  localparam int TRIG_BITS = 15;
  localparam int STEPS_PER_TURN = 400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int BINS_PER_PHASE = 180;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [9:0]  az_step;
    logic [15:0] enc_az;
    logic [11:0] bin_num;
    logic [7:0]  power;
    logic        row_end;
  } radar_bin_t;

  typedef struct {
    logic               point;
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic [7:0]         intensity;
    logic               frame_end;
  } radar_point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [9:0] in_azimuth_step = '0;
  logic [15:0] in_encoder_azimuth = '0;
  logic [11:0] in_bin_number = '0;
  logic [7:0] in_bin_power = '0;
  logic in_row_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_point_valid;
  logic signed [16:0] out_x_pos;
  logic signed [16:0] out_y_pos;
  logic [7:0] out_intensity;
  logic out_frame_end;

  radar_bin_t pending_bins[$];
  radar_bin_t cur_bin;
  radar_point_t points_due[$];
  radar_point_t want_pt;
  cfg_t model_cfg;
  logic [15:0] last_row_enc = '0;
  logic [15:0] enc_now = '0;
  logic [15:0] sine_q [0:STEPS_PER_QUARTER];
  bit idle_on = 1'b1;
  int send_gap = 0;
  int hold_left = 0;
  int fail_count = 0;
  int cycle_count = 0;

  radar_bin_threshold_to_points_top #(.TRIG_FRAC_BITS(TRIG_BITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_azimuth_step(in_azimuth_step),
    .in_encoder_azimuth(in_encoder_azimuth), .in_bin_number(in_bin_number),
    .in_bin_power(in_bin_power), .in_row_last(in_row_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_point_valid(out_point_valid),
    .out_x_pos(out_x_pos), .out_y_pos(out_y_pos), .out_intensity(out_intensity),
    .out_frame_end(out_frame_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] taylor_sine(input int k);
    logic [63:0] ang;
    logic [63:0] ang2;
    logic [63:0] term;
    logic [63:0] v;
    longint sum;
    bit plus;
    ang = (64'(k) * PI_Q30 + 64'd100) / 64'd200;
    ang2 = (ang * ang) >> 30;
    term = ang;
    sum = 0;
    plus = 1'b1;
    for (int n = 1; n <= 21; n += 2) begin
      if (plus) begin
        sum = sum + longint'(term);
      end else begin
        sum = sum - longint'(term);
      end
      plus = !plus;
      term = ((term * ang2) >> 30) / 64'((n + 1) * (n + 2));
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (64'(sum) + (64'd1 << (29 - TRIG_BITS))) >> (30 - TRIG_BITS);
    if (v > (64'd1 << TRIG_BITS)) begin
      v = 64'd1 << TRIG_BITS;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [16:0] to_q4(input logic [11:0] bin_num,
                                               input logic [15:0] mag, input logic neg);
    logic [31:0] prod;
    prod = (32'(bin_num) * 32'(mag) + (32'd1 << (TRIG_BITS - 5))) >> (TRIG_BITS - 4);
    if (neg) begin
      prod = -prod;
    end
    return prod[16:0];
  endfunction

  task automatic derive_point(input radar_bin_t b);
    radar_point_t p;
    logic hit;
    logic fe;
    int adj;
    int s;
    int r;
    logic [15:0] cmag;
    logic [15:0] smag;
    logic cneg;
    logic sneg;
    hit = {1'b0, b.az_step} >= model_cfg.az_win_start &&
          {1'b0, b.az_step} < model_cfg.az_win_end &&
          {1'b0, b.bin_num} >= model_cfg.bin_win_start &&
          {1'b0, b.bin_num} < model_cfg.bin_win_end &&
          b.power > model_cfg.pwr_thresh;
    p = '{point: 1'b0, x: '0, y: '0, intensity: '0, frame_end: 1'b0};
    fe = 1'b0;
    if (hit) begin
      adj = int'(b.az_step) + int'(model_cfg.az_offset);
      if (adj >= int'(model_cfg.az_count)) begin
        adj = adj - int'(model_cfg.az_count);
      end
      s = adj % STEPS_PER_TURN;
      r = s % STEPS_PER_QUARTER;
      case (quad_t'(s / STEPS_PER_QUARTER))
        QUAD_0: begin
          cmag = sine_q[STEPS_PER_QUARTER - r]; cneg = 1'b0;
          smag = sine_q[r]; sneg = 1'b0;
        end
        QUAD_1: begin
          cmag = sine_q[r]; cneg = 1'b1;
          smag = sine_q[STEPS_PER_QUARTER - r]; sneg = 1'b0;
        end
        QUAD_2: begin
          cmag = sine_q[STEPS_PER_QUARTER - r]; cneg = 1'b1;
          smag = sine_q[r]; sneg = 1'b1;
        end
        default: begin
          cmag = sine_q[r]; cneg = 1'b0;
          smag = sine_q[STEPS_PER_QUARTER - r]; sneg = 1'b1;
        end
      endcase
      p.point = 1'b1;
      p.x = to_q4(b.bin_num, cmag, cneg);
      p.y = to_q4(b.bin_num, smag, sneg);
      p.intensity = b.power;
    end
    if (b.row_end) begin
      fe = b.enc_az < last_row_enc;
      last_row_enc = b.enc_az;
    end
    p.frame_end = fe;
    if (hit || fe) begin
      points_due = {points_due, p};
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        derive_point(cur_bin);
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_bins.size() != 0) begin
          cur_bin = pending_bins.pop_front();
          in_azimuth_step <= cur_bin.az_step;
          in_encoder_azimuth <= cur_bin.enc_az;
          in_bin_number <= cur_bin.bin_num;
          in_bin_power <= cur_bin.power;
          in_row_last <= cur_bin.row_end;
          in_valid <= 1'b1;
          send_gap = idle_on ? $urandom_range(0, 5) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (points_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result: point=%0d x=%0d y=%0d intensity=%0d frame_end=%0d",
                     out_point_valid, out_x_pos, out_y_pos, out_intensity, out_frame_end);
          end
        end else begin
          want_pt = points_due.pop_front();
          if (want_pt.point !== out_point_valid || want_pt.x !== out_x_pos ||
              want_pt.y !== out_y_pos || want_pt.intensity !== out_intensity ||
              want_pt.frame_end !== out_frame_end) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: expected point=%0d x=%0d y=%0d intensity=%0d frame_end=%0d",
                       want_pt.point, want_pt.x, want_pt.y, want_pt.intensity,
                       want_pt.frame_end);
              $display("          actual   point=%0d x=%0d y=%0d intensity=%0d frame_end=%0d",
                       out_point_valid, out_x_pos, out_y_pos, out_intensity, out_frame_end);
            end
          end
        end
        hold_left = idle_on ? $urandom_range(0, 5) : 0;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [12:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    case (idx)
      REG_AZ_COUNT: model_cfg.az_count = data[10:0];
      REG_AZ_OFFSET: model_cfg.az_offset = data[10:0];
      REG_AZ_WIN_START: model_cfg.az_win_start = data[10:0];
      REG_AZ_WIN_END: model_cfg.az_win_end = data[10:0];
      REG_BIN_WIN_START: model_cfg.bin_win_start = data;
      REG_BIN_WIN_END: model_cfg.bin_win_end = data;
      REG_PWR_THRESH: model_cfg.pwr_thresh = data[7:0];
      default: ;
    endcase
  endtask

  task automatic program_all(input logic [12:0] count, input logic [12:0] offset,
                             input logic [12:0] az_lo, input logic [12:0] az_hi,
                             input logic [12:0] bin_lo, input logic [12:0] bin_hi,
                             input logic [12:0] thresh);
    @(posedge clk);
    write_reg(REG_AZ_COUNT, count);
    write_reg(REG_AZ_OFFSET, offset);
    write_reg(REG_AZ_WIN_START, az_lo);
    write_reg(REG_AZ_WIN_END, az_hi);
    write_reg(REG_BIN_WIN_START, bin_lo);
    write_reg(REG_BIN_WIN_END, bin_hi);
    write_reg(REG_PWR_THRESH, thresh);
    write_reg(REG_UNUSED, 13'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (pending_bins.size() != 0 || in_valid || points_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (10) @(negedge clk);
  endtask

  task automatic queue_bin(input int az_step, input int enc_az, input int bin_num,
                           input int power, input bit row_end);
    radar_bin_t b;
    b.az_step = az_step[9:0];
    b.enc_az = enc_az[15:0];
    b.bin_num = bin_num[11:0];
    b.power = power[7:0];
    b.row_end = row_end;
    pending_bins = {pending_bins, b};
  endtask

  task automatic random_setup();
    logic [12:0] count;
    logic [12:0] offset;
    int az_lo;
    int az_hi;
    int bin_lo;
    int bin_hi;
    int thresh;
    case ($urandom_range(0, 5))
      0: count = 13'd400;
      1: count = 13'd1024;
      2: count = 13'($urandom_range(1, 1024));
      3: count = 13'($urandom_range(0, 1));
      4: count = 13'($urandom);
      default: count = 13'($urandom_range(350, 450));
    endcase
    case ($urandom_range(0, 3))
      0: offset = 13'd0;
      1: offset = 13'($urandom);
      default: offset = 13'($urandom_range(0, 1024));
    endcase
    az_lo = $urandom_range(0, 700);
    az_hi = az_lo + $urandom_range(1, 1024 - az_lo);
    if ($urandom_range(0, 7) == 0) begin
      az_hi = $urandom_range(0, az_lo);
    end
    bin_lo = $urandom_range(0, 3500);
    bin_hi = bin_lo + $urandom_range(1, 4096 - bin_lo);
    if ($urandom_range(0, 7) == 0) begin
      bin_hi = $urandom_range(0, bin_lo);
    end
    case ($urandom_range(0, 4))
      0: thresh = 0;
      1: thresh = 255;
      default: thresh = $urandom_range(0, 200);
    endcase
    if ($urandom_range(0, 5) == 0) begin
      program_all(count, offset, 13'($urandom), 13'($urandom), 13'($urandom),
                  13'($urandom), 13'($urandom));
    end else begin
      program_all(count, offset, 13'(az_lo), 13'(az_hi), 13'(bin_lo), 13'(bin_hi),
                  13'(thresh | ($urandom & 32'h1F00)));
    end
  endtask

  task automatic queue_row(output int queued);
    int nb;
    int first_bin;
    int az_step;
    int lo;
    int hi;
    nb = $urandom_range(1, 20);
    lo = int'(model_cfg.az_win_start);
    hi = int'(model_cfg.az_win_end) - 1;
    if (hi > 1023) begin
      hi = 1023;
    end
    if (lo <= hi && $urandom_range(0, 4) != 0) begin
      az_step = $urandom_range(lo, hi);
    end else begin
      az_step = $urandom_range(0, 1023);
    end
    lo = int'(model_cfg.bin_win_start) - 3;
    hi = int'(model_cfg.bin_win_end);
    if (lo < 0) begin
      lo = 0;
    end
    if (hi > 4095) begin
      hi = 4095;
    end
    if (lo > hi || $urandom_range(0, 4) == 0) begin
      lo = 0;
      hi = 4095;
    end
    first_bin = $urandom_range(lo, hi);
    if (first_bin + nb > 4096) begin
      first_bin = 4096 - nb;
    end
    if ($urandom_range(0, 7) == 0) begin
      enc_now = 16'($urandom_range(0, enc_now));
    end else begin
      enc_now = enc_now + 16'($urandom_range(0, 900));
    end
    for (int i = 0; i < nb; i++) begin
      queue_bin(az_step, enc_now, first_bin + i, $urandom_range(0, 255), i == nb - 1);
    end
    queued = nb;
  endtask

  initial begin
    int queued;
    int row_bins;
    model_cfg.az_count = 11'd400;
    model_cfg.az_offset = '0;
    model_cfg.az_win_start = '0;
    model_cfg.az_win_end = '0;
    model_cfg.bin_win_start = '0;
    model_cfg.bin_win_end = '0;
    model_cfg.pwr_thresh = '0;
    for (int k = 0; k <= STEPS_PER_QUARTER; k++) begin
      sine_q[k] = taylor_sine(k);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Power-up settings: empty windows, so only frame ends come out.
    queue_bin(0, 100, 0, 255, 1);
    queue_bin(5, 50, 10, 255, 1);
    settle();

    program_all(13'd400, 13'd0, 13'd0, 13'd1024, 13'd0, 13'd4096, 13'd0);
    queue_bin(0, 200, 4095, 255, 0);
    queue_bin(100, 200, 4095, 1, 0);
    queue_bin(200, 200, 4095, 128, 0);
    queue_bin(300, 200, 4095, 7, 0);
    queue_bin(399, 200, 1000, 64, 0);
    queue_bin(1023, 200, 0, 255, 0);
    queue_bin(50, 200, 2000, 0, 0);
    queue_bin(150, 300, 3000, 200, 1);
    queue_bin(250, 10, 123, 99, 1);
    settle();

    program_all(13'd1, 13'd1024, 13'd10, 13'd20, 13'd100, 13'd200, 13'd100);
    queue_bin(9, 0, 150, 200, 0);
    queue_bin(10, 0, 100, 101, 0);
    queue_bin(19, 0, 199, 255, 0);
    queue_bin(20, 0, 150, 255, 0);
    queue_bin(15, 0, 99, 255, 0);
    queue_bin(15, 0, 200, 255, 0);
    queue_bin(15, 0, 150, 100, 0);
    settle();

    program_all(13'd0, 13'd1024, 13'd20, 13'd10, 13'd200, 13'd100, 13'd255);
    queue_bin(15, 65535, 150, 255, 1);
    queue_bin(15, 0, 150, 255, 1);
    settle();

    program_all(13'h1C00, 13'h1C00, 13'd0, 13'h1C00, 13'd0, 13'd4096, 13'd0);
    queue_bin(1023, 1, 4095, 255, 0);
    queue_bin(500, 2, 2048, 17, 1);
    settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_on = (ph == 3) ? 1'b0 : ($urandom_range(0, 5) != 0);
      random_setup();
      queued = 0;
      while (queued < BINS_PER_PHASE) begin
        if ($urandom_range(0, 6) == 0) begin
          queue_bin($urandom_range(0, 1023), $urandom_range(0, 65535),
                    $urandom_range(0, 4095), $urandom_range(0, 255),
                    1'($urandom_range(0, 1)));
          queued++;
        end else begin
          queue_row(row_bins);
          queued += row_bins;
        end
      end
      settle();
    end

    repeat (10) @(negedge clk);
    if (fail_count == 0 && points_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/rbtp_pkg.sv
hdl/rbtp_cfg_regs.sv
hdl/rbtp_front.sv
hdl/rbtp_polar.sv
hdl/radar_bin_threshold_to_points_top.sv
verif/radar_bin_threshold_to_points_top_test.sv
